// ----- rtl/shgb_pkg.sv -----
`default_nettype none
package shgb_pkg;

   // Default sizes of the grid and of the angle codes.
   localparam int MAX_RINGS_DEF  = 256;
   localparam int MAX_POINTS_DEF = 1024;
   localparam int ANGLE_BITS_DEF = 16;

   // Register map of the configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_RING_COUNT      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_POINTS_PER_RING = 2'd1;

   // Register values after reset.
   localparam logic [8:0]  RING_COUNT_RST      = 9'd16;
   localparam logic [10:0] POINTS_PER_RING_RST = 11'd64;

   // Pipeline depths of the sine unit and of the product stages.
   localparam int SIN_LAT  = 9;
   localparam int PROD_LAT = 3;

   // Signed Q2.30 value with headroom for magnitudes below four.
   typedef logic signed [32:0] qval_type;

   localparam qval_type Q30_ONE = 33'sd1073741824;
   localparam qval_type K_Y00   = 33'sd302896976;
   localparam qval_type K_Y1    = 33'sd524632952;
   localparam qval_type K_Y20   = 33'sd338649115;
   localparam qval_type K_Y21   = 33'sd1173114945;
   localparam qval_type K_Y22   = 33'sd586557472;

   // Taylor coefficients of sin(pi/2 * t) in Q30, lowest order first.
   localparam logic [31:0] SIN_COEF [6] = '{
      32'd1686629713, 32'd693598668, 32'd85569306,
      32'd5026995, 32'd172272, 32'd3864
   };

   typedef struct packed {
      logic [7:0] ring_index;
      logic [9:0] point_index;
   } req_type;

   typedef struct packed {
      logic               in_range;
      logic signed [15:0] y_0_0;
      logic signed [15:0] y_1_0;
      logic signed [15:0] y_1_pos1;
      logic signed [15:0] y_1_neg1;
      logic signed [15:0] y_2_0;
      logic signed [15:0] y_2_pos1;
      logic signed [15:0] y_2_neg1;
      logic signed [15:0] y_2_pos2;
      logic signed [15:0] y_2_neg2;
   } rsp_type;

   // Sines and cosines of one grid point.
   typedef struct packed {
      qval_type st;
      qval_type ct;
      qval_type sp;
      qval_type cp;
      qval_type s2p;
      qval_type c2p;
   } trig_type;

   // Harmonics in Q2.30 before the final rounding.
   typedef struct packed {
      qval_type y10;
      qval_type y11;
      qval_type y1n;
      qval_type y20;
      qval_type y21;
      qval_type y2n1;
      qval_type y22;
      qval_type y2n2;
   } prod_type;

   // Q2.30 product, rounded half away from zero.
   function automatic qval_type mulq(qval_type a, qval_type b);
      logic        neg;
      logic [31:0] ma;
      logic [31:0] mb;
      logic [63:0] p;
      logic [32:0] r;
      neg = a[32] ^ b[32];
      ma  = a[32] ? 32'(-a) : 32'(a);
      mb  = b[32] ? 32'(-b) : 32'(b);
      p   = 64'(ma) * 64'(mb) + 64'd536870912;
      r   = p[62:30];
      return neg ? -$signed(r) : $signed(r);
   endfunction

   // Q2.30 to Q1.15, rounded half away from zero and saturated.
   function automatic logic signed [15:0] to_q15(qval_type v);
      logic [32:0] mag;
      logic [17:0] r;
      logic [15:0] res;
      mag = v[32] ? 33'(-v) : 33'(v);
      r   = 18'((mag + 33'd16384) >> 15);
      if (!v[32]) begin
         res = (r > 18'd32767) ? 16'h7FFF : r[15:0];
      end else begin
         res = (r >= 18'd32768) ? 16'h8000 : 16'(-r[15:0]);
      end
      return $signed(res);
   endfunction

   localparam logic signed [15:0] Y00_Q15 = to_q15(K_Y00);

endpackage
`default_nettype wire

// ----- rtl/shgb_div.sv -----
`default_nettype none
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// The user, not this block, holds the divisor while words are in flight.
module shgb_div #(
   parameter int NUM_W = 26,
   parameter int DEN_W = 10,
   parameter int QUO_W = 17
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [QUO_W-1:0] quo
);
   localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

   logic [REM_W-1:0] rem_ff [QUO_W];
   logic [REM_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int BIT = QUO_W - 1 - k;
      logic [REM_W-1:0] rem_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [REM_W-1:0] trial;

      // The first stage starts from the numerator.
      if (k == 0) begin : g_first
         assign rem_prev = REM_W'(num);
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      // Subtract the shifted divisor where it fits.
      always_comb begin
         trial = REM_W'(den) << BIT;
         if (rem_prev >= trial) begin
            rem_in[k] = rem_prev - trial;
            quo_in[k] = quo_prev | (QUO_W'(1) << BIT);
         end else begin
            rem_in[k] = rem_prev;
            quo_in[k] = quo_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule
`default_nettype wire

// ----- rtl/shgb_sine.sv -----
`default_nettype none
// Sine of an angle code in nine stages: quadrant fold, square, five Horner
// steps, final multiply, then clamp and sign.
module shgb_sine #(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire logic [ANGLE_BITS-1:0] code,
   output shgb_pkg::qval_type         sine
);
   import shgb_pkg::*;

   localparam int FW = ANGLE_BITS - 1;

   logic [1:0]    quad;
   logic [FW-1:0] frac;
   logic [FW-1:0] fold;
   logic [30:0]   t1_in;
   logic [30:0]   t1_ff;
   logic          n1_ff;
   logic [61:0]   sq_full;
   logic [30:0]   sq_ff;
   logic [30:0]   t2_ff;
   logic          n2_ff;
   logic [31:0]   acc_ff [5];
   logic [31:0]   acc_in [5];
   logic [30:0]   th_ff  [5];
   logic [30:0]   sqh_ff [5];
   logic          nh_ff  [5];
   logic [62:0]   fin_full;
   logic [31:0]   mag_ff;
   logic          n8_ff;
   logic [31:0]   clamp;
   qval_type      sine_ff;

   // Fold the angle into the first quarter turn.
   always_comb begin
      quad  = code[ANGLE_BITS-1 -: 2];
      frac  = FW'(code[ANGLE_BITS-3:0]);
      fold  = quad[0] ? (FW'(1) << (ANGLE_BITS - 2)) - frac : frac;
      t1_in = 31'(fold) << (32 - ANGLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff <= t1_in;
         n1_ff <= quad[1];
      end
   end

   // Square of the folded fraction.
   assign sq_full = 62'(t1_ff) * 62'(t1_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_full[60:30];
         t2_ff <= t1_ff;
         n2_ff <= n1_ff;
      end
   end

   // Horner steps of the odd polynomial, one multiply each.
   for (genvar j = 0; j < 5; j++) begin : g_horner
      logic [31:0] acc_prev;
      logic [30:0] sq_prev;
      logic [30:0] t_prev;
      logic        n_prev;
      logic [62:0] prod;

      if (j == 0) begin : g_first
         assign acc_prev = SIN_COEF[5];
         assign sq_prev  = sq_ff;
         assign t_prev   = t2_ff;
         assign n_prev   = n2_ff;
      end else begin : g_next
         assign acc_prev = acc_ff[j-1];
         assign sq_prev  = sqh_ff[j-1];
         assign t_prev   = th_ff[j-1];
         assign n_prev   = nh_ff[j-1];
      end

      assign prod      = 63'(sq_prev) * 63'(acc_prev);
      assign acc_in[j] = SIN_COEF[4-j] - prod[61:30];

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[j] <= acc_in[j];
            sqh_ff[j] <= sq_prev;
            th_ff[j]  <= t_prev;
            nh_ff[j]  <= n_prev;
         end
      end
   end

   // Final multiply by the fraction.
   assign fin_full = 63'(th_ff[4]) * 63'(acc_ff[4]);

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= fin_full[61:30];
         n8_ff  <= nh_ff[4];
      end
   end

   // Clamp to one and apply the sign of the lower half turn.
   assign clamp = (mag_ff > 32'd1073741824) ? 32'd1073741824 : mag_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sine_ff <= n8_ff ? -qval_type'({1'b0, clamp}) : qval_type'({1'b0, clamp});
      end
   end

   assign sine = sine_ff;

endmodule
`default_nettype wire

// ----- rtl/shgb_prod.sv -----
`default_nettype none
// Harmonic products in three stages, one multiply deep per stage.
module shgb_prod (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire shgb_pkg::trig_type trig,
   output shgb_pkg::prod_type      prod
);
   import shgb_pkg::*;

   // First stage registers.
   qval_type ksp_ff, stct_ff, stst_ff, ctct_ff, y10_a_ff;
   qval_type sp_a_ff, cp_a_ff, s2p_a_ff, c2p_a_ff;
   // Second stage registers.
   qval_type sct_ff, ss_ff, v_ff, y11_b_ff, y1n_b_ff, y10_b_ff;
   qval_type sp_b_ff, cp_b_ff, s2p_b_ff, c2p_b_ff;
   qval_type v_in;
   prod_type prod_ff;

   // Products of the ring angle terms.
   always_ff @(posedge clock) begin
      if (en) begin
         ksp_ff   <= mulq(K_Y1, trig.st);
         stct_ff  <= mulq(trig.st, trig.ct);
         stst_ff  <= mulq(trig.st, trig.st);
         ctct_ff  <= mulq(trig.ct, trig.ct);
         y10_a_ff <= mulq(K_Y1, trig.ct);
         sp_a_ff  <= trig.sp;
         cp_a_ff  <= trig.cp;
         s2p_a_ff <= trig.s2p;
         c2p_a_ff <= trig.c2p;
      end
   end

   // Scaled ring terms and the degree one azimuth products.
   assign v_in = (ctct_ff <<< 1) + ctct_ff - Q30_ONE;

   always_ff @(posedge clock) begin
      if (en) begin
         sct_ff   <= mulq(K_Y21, stct_ff);
         ss_ff    <= mulq(K_Y22, stst_ff);
         v_ff     <= v_in;
         y11_b_ff <= mulq(ksp_ff, cp_a_ff);
         y1n_b_ff <= mulq(ksp_ff, sp_a_ff);
         y10_b_ff <= y10_a_ff;
         sp_b_ff  <= sp_a_ff;
         cp_b_ff  <= cp_a_ff;
         s2p_b_ff <= s2p_a_ff;
         c2p_b_ff <= c2p_a_ff;
      end
   end

   // Degree two products; the degree one results pass along.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff.y10  <= y10_b_ff;
         prod_ff.y11  <= y11_b_ff;
         prod_ff.y1n  <= y1n_b_ff;
         prod_ff.y20  <= mulq(K_Y20, v_ff);
         prod_ff.y21  <= mulq(sct_ff, cp_b_ff);
         prod_ff.y2n1 <= mulq(sct_ff, sp_b_ff);
         prod_ff.y22  <= mulq(ss_ff, c2p_b_ff);
         prod_ff.y2n2 <= mulq(ss_ff, s2p_b_ff);
      end
   end

   assign prod = prod_ff;

endmodule
`default_nettype wire

// ----- rtl/spherical_harmonic_grid_basis_core.sv -----
`default_nettype none
// Real spherical harmonics of degrees 0 to 2 on a ring and point viewing grid.
// A request word carries a ring index and a point index; the response word
// carries in_range and the nine harmonic values in signed Q1.15. Outside the
// rings 1..ring_count-2 or past the last point, in_range is 0 and values are
// 0; both counts are capped at MAX_RINGS and MAX_POINTS. The csr channel
// writes ring_count (index 0) and points_per_ring (index 1); it is always
// ready and should be used only while no word is in flight. Throughput is
// one word per cycle unless a full skid register holds the pipeline. From
// request accept to response valid a word passes one front stage, a divider
// pipeline of ANGLE_BITS + 1 stages forming the angle codes one quotient bit
// per stage, nine sine stages, three product stages and the output register.
// When the receiver stalls, a skid register takes one more word; once it is
// full the pipeline holds and req_ready drops, and nothing is lost.
// Synchronous reset empties the pipeline and restores ring_count to 16 and
// points_per_ring to 64.
module spherical_harmonic_grid_basis_core #(
   parameter int MAX_RINGS  = shgb_pkg::MAX_RINGS_DEF,
   parameter int MAX_POINTS = shgb_pkg::MAX_POINTS_DEF,
   parameter int ANGLE_BITS = shgb_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire shgb_pkg::req_type                  req_payload,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output shgb_pkg::rsp_type                       rsp_payload,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [shgb_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [shgb_pkg::CSR_DATA_W-1:0]    csr_data
);
   import shgb_pkg::*;

   localparam int A     = ANGLE_BITS;
   localparam int QB    = A + 1;
   localparam int NRW   = $clog2(MAX_RINGS + 1);
   localparam int NPW   = $clog2(MAX_POINTS + 1);
   localparam int CRW   = (NRW > 9) ? NRW : 9;
   localparam int CPW   = (NPW > 11) ? NPW : 11;
   localparam int RCW   = ((NRW > 8) ? NRW : 8) + 1;
   localparam int PCW   = (NPW > 10) ? NPW : 10;
   localparam int TW    = NRW + A + 1;
   localparam int PW    = PCW + A + 2;
   localparam int LAT   = 1 + QB + SIN_LAT + PROD_LAT;

   logic [8:0]     ring_count_ff;
   logic [10:0]    points_ff;
   logic [NRW-1:0] nr;
   logic [NPW-1:0] np;
   logic           en;
   logic           in_range_in;
   logic [RCW-1:0] ring_ext;
   logic [NRW-1:0] diff;
   logic [TW-1:0]  num_t_ff;
   logic [PW-1:0]  num_p_ff;
   logic [QB-1:0]  quo_t;
   logic [QB-1:0]  quo_p;
   logic [A-1:0]   tc;
   logic [A-1:0]   pc;
   logic [A-1:0]   pc2;
   logic           vld_ff [LAT];
   logic           rng_ff [LAT];
   trig_type       trig;
   prod_type       prod;
   rsp_type        rsp_in;
   rsp_type        rsp_payload_ff;
   rsp_type        skid_ff;
   logic           rsp_valid_ff;
   logic           skid_vld_ff;
   logic           push;
   logic           take;

   localparam logic [A-1:0] QUARTER = A'(1) << (A - 2);
   localparam logic [A-1:0] HALF    = A'(1) << (A - 1);

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff <= RING_COUNT_RST;
         points_ff     <= POINTS_PER_RING_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RING_COUNT:      ring_count_ff <= csr_data[8:0];
            CSR_POINTS_PER_RING: points_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Grid sizes limited to the largest supported grid.
   assign nr = (CRW'(ring_count_ff) > CRW'(MAX_RINGS)) ? NRW'(MAX_RINGS)
                                                       : NRW'(ring_count_ff);
   assign np = (CPW'(points_ff) > CPW'(MAX_POINTS)) ? NPW'(MAX_POINTS)
                                                    : NPW'(points_ff);

   // The whole pipeline moves unless the skid register is full.
   assign en        = !skid_vld_ff;
   assign req_ready = en;

   // Range check and dividends for the two angle codes.
   always_comb begin
      ring_ext    = RCW'(req_payload.ring_index);
      in_range_in = (ring_ext >= RCW'(1)) && (ring_ext + RCW'(2) <= RCW'(nr))
                    && (PCW'(req_payload.point_index) < PCW'(np));
      diff        = in_range_in ? NRW'(RCW'(nr) - ring_ext) : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_t_ff <= (TW'(diff) << A) + TW'(nr);
         num_p_ff <= (PW'(req_payload.point_index) << (A + 1)) + PW'(np);
      end
   end

   // Valid and range flags travel beside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rng_ff[0] <= in_range_in;
         for (int i = 1; i < LAT; i++) begin
            rng_ff[i] <= rng_ff[i-1];
         end
      end
   end

   // Inclination and azimuth codes.
   shgb_div #(.NUM_W(TW), .DEN_W(NRW + 1), .QUO_W(QB)) u_div_t (
      .clock (clock),
      .en    (en),
      .num   (num_t_ff),
      .den   ((NRW + 1)'(nr) << 1),
      .quo   (quo_t)
   );

   shgb_div #(.NUM_W(PW), .DEN_W(NPW + 1), .QUO_W(QB)) u_div_p (
      .clock (clock),
      .en    (en),
      .num   (num_p_ff),
      .den   ((NPW + 1)'(np) << 1),
      .quo   (quo_p)
   );

   assign tc  = quo_t[A-1:0];
   assign pc  = HALF - quo_p[A-1:0];
   assign pc2 = {pc[A-2:0], 1'b0};

   // Six sine units for the ring angle, azimuth and doubled azimuth.
   shgb_sine #(.ANGLE_BITS(A)) u_sin_t (
      .clock (clock), .en (en), .code (tc), .sine (trig.st)
   );
   shgb_sine #(.ANGLE_BITS(A)) u_cos_t (
      .clock (clock), .en (en), .code (tc + QUARTER), .sine (trig.ct)
   );
   shgb_sine #(.ANGLE_BITS(A)) u_sin_p (
      .clock (clock), .en (en), .code (pc), .sine (trig.sp)
   );
   shgb_sine #(.ANGLE_BITS(A)) u_cos_p (
      .clock (clock), .en (en), .code (pc + QUARTER), .sine (trig.cp)
   );
   shgb_sine #(.ANGLE_BITS(A)) u_sin_2p (
      .clock (clock), .en (en), .code (pc2), .sine (trig.s2p)
   );
   shgb_sine #(.ANGLE_BITS(A)) u_cos_2p (
      .clock (clock), .en (en), .code (pc2 + QUARTER), .sine (trig.c2p)
   );

   shgb_prod u_prod (
      .clock (clock),
      .en    (en),
      .trig  (trig),
      .prod  (prod)
   );

   // Final rounding to Q1.15; out-of-range points give zeros.
   always_comb begin
      rsp_in.in_range = rng_ff[LAT-1];
      if (rng_ff[LAT-1]) begin
         rsp_in.y_0_0    = Y00_Q15;
         rsp_in.y_1_0    = to_q15(prod.y10);
         rsp_in.y_1_pos1 = to_q15(prod.y11);
         rsp_in.y_1_neg1 = to_q15(prod.y1n);
         rsp_in.y_2_0    = to_q15(prod.y20);
         rsp_in.y_2_pos1 = to_q15(prod.y21);
         rsp_in.y_2_neg1 = to_q15(prod.y2n1);
         rsp_in.y_2_pos2 = to_q15(prod.y22);
         rsp_in.y_2_neg2 = to_q15(prod.y2n2);
      end else begin
         rsp_in.y_0_0    = '0;
         rsp_in.y_1_0    = '0;
         rsp_in.y_1_pos1 = '0;
         rsp_in.y_1_neg1 = '0;
         rsp_in.y_2_0    = '0;
         rsp_in.y_2_pos1 = '0;
         rsp_in.y_2_neg1 = '0;
         rsp_in.y_2_pos2 = '0;
         rsp_in.y_2_neg2 = '0;
      end
   end

   // Output register with one skid word behind it.
   assign push = en && vld_ff[LAT-1];
   assign take = rsp_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_vld_ff  <= 1'b0;
      end else if (take) begin
         if (skid_vld_ff) begin
            skid_vld_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= push;
         end
      end else if (push) begin
         if (rsp_valid_ff) begin
            skid_vld_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && skid_vld_ff) begin
         rsp_payload_ff <= skid_ff;
      end else if (push && (take || !rsp_valid_ff)) begin
         rsp_payload_ff <= rsp_in;
      end
      if (push && rsp_valid_ff && !take) begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef SYNTHESIS
   // A word in the skid register always has one ahead of it.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> rsp_valid_ff)
      else $error("skid word without an output word");

   // A held pipeline keeps its last word.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!en && vld_ff[LAT-1]) |=> vld_ff[LAT-1])
      else $error("pipeline lost a word during a stall");

   // Out-of-range words carry zeros in y_0_0, y_1_0, y_2_0 and y_2_neg2.
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_payload_ff.in_range) |->
      (rsp_payload_ff.y_0_0 == 16'sd0 && rsp_payload_ff.y_1_0 == 16'sd0 &&
       rsp_payload_ff.y_2_0 == 16'sd0 && rsp_payload_ff.y_2_neg2 == 16'sd0))
      else $error("out-of-range word with nonzero values");

   // In-range words carry the constant harmonic.
   a_const_term: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_payload_ff.in_range) |-> rsp_payload_ff.y_0_0 == Y00_Q15)
      else $error("constant harmonic is wrong");
`endif

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
module tb_top;
   import shgb_pkg::*;

   // Register index that decodes to no register.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd2;
   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 230;
   localparam int HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Testbench copy of the grid registers.
   logic [8:0] grid_rings = RING_COUNT_RST;
   logic [10:0] grid_points = POINTS_PER_RING_RST;

   req_type grid_words[$];
   rsp_type harmonic_exp[$];
   int send_idle = 0;
   int recv_stall = 0;
   int words_sent = 0;
   int hold_left = 0;
   bit hold_done = 0;
   int quiet_cycles = 0;
   int error_count = 0;

   spherical_harmonic_grid_basis_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Sine of an angle code, Q2.30, from a folded odd polynomial.
   function automatic longint sine_of(longint unsigned code);
      longint unsigned coef[6];
      longint unsigned quad, frac, t, t2, acc;
      coef = '{64'd1686629713, 64'd693598668, 64'd85569306,
               64'd5026995, 64'd172272, 64'd3864};
      code = code & 64'hFFFF;
      quad = code >> 14;
      frac = code & 64'h3FFF;
      if (quad[0]) frac = 64'h4000 - frac;
      t = frac << 16;
      t2 = (t * t) >> 30;
      acc = coef[5];
      for (int k = 4; k >= 0; k--) acc = coef[k] - ((t2 * acc) >> 30);
      acc = (t * acc) >> 30;
      if (acc > 64'd1073741824) acc = 64'd1073741824;
      return (quad >= 2) ? -longint'(acc) : longint'(acc);
   endfunction

   // Q2.30 product rounded half away from zero.
   function automatic longint qmul(longint a, longint b);
      longint unsigned ma, mb, p;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = (ma * mb + 64'd536870912) >> 30;
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
   endfunction

   // Q2.30 to Q1.15 with rounding and saturation.
   function automatic logic signed [15:0] q15_of(longint v);
      longint unsigned mag;
      longint r;
      mag = (v < 0) ? -v : v;
      r = longint'((mag + 64'd16384) >> 15);
      if (v < 0) r = -r;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // Harmonic basis values at one grid point under the current registers.
   function automatic rsp_type harmonics_at(req_type w);
      longint unsigned nr, np, tcode, pcode, pstep;
      longint st, ct, sp, cp, s2p, c2p, ksp, sct, ss;
      rsp_type r;
      r = '0;
      nr = (grid_rings > 256) ? 256 : grid_rings;
      np = (grid_points > 1024) ? 1024 : grid_points;
      if (w.ring_index < 1 || w.ring_index + 2 > nr || w.point_index >= np) return r;
      tcode = ((nr - w.ring_index) * 65536 + nr) / (2 * nr);
      pstep = (w.point_index * 131072 + np) / (2 * np);
      pcode = (64'd32768 - pstep) & 64'hFFFF;
      st = sine_of(tcode);
      ct = sine_of(tcode + 16384);
      sp = sine_of(pcode);
      cp = sine_of(pcode + 16384);
      s2p = sine_of(pcode << 1);
      c2p = sine_of((pcode << 1) + 16384);
      ksp = qmul(524632952, st);
      sct = qmul(1173114945, qmul(st, ct));
      ss = qmul(586557472, qmul(st, st));
      r.in_range = 1'b1;
      r.y_0_0 = q15_of(302896976);
      r.y_1_0 = q15_of(qmul(524632952, ct));
      r.y_1_pos1 = q15_of(qmul(ksp, cp));
      r.y_1_neg1 = q15_of(qmul(ksp, sp));
      r.y_2_0 = q15_of(qmul(338649115, 3 * qmul(ct, ct) - 1073741824));
      r.y_2_pos1 = q15_of(qmul(sct, cp));
      r.y_2_neg1 = q15_of(qmul(sct, sp));
      r.y_2_pos2 = q15_of(qmul(ss, c2p));
      r.y_2_neg2 = q15_of(qmul(ss, s2p));
      return r;
   endfunction

   task automatic check_field(string name, int expv, int actv);
      if (expv != actv) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, expv, actv);
         error_count++;
      end
   endtask

   // Driver: offers grid words from the queue and records their expectations.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            harmonic_exp.insert(harmonic_exp.size(), harmonics_at(req_payload));
            words_sent++;
         end
         if (!req_valid || req_ready) begin
            if (grid_words.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_valid <= 1'b1;
               req_payload <= grid_words.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each response word and paces rsp_ready.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (harmonic_exp.size() == 0) begin
               $display("%0t: unexpected response word %h", $time, rsp_payload);
               error_count++;
            end else begin
               e = harmonic_exp.pop_front();
               check_field("in_range", e.in_range, rsp_payload.in_range);
               check_field("y_0_0", e.y_0_0, rsp_payload.y_0_0);
               check_field("y_1_0", e.y_1_0, rsp_payload.y_1_0);
               check_field("y_1_pos1", e.y_1_pos1, rsp_payload.y_1_pos1);
               check_field("y_1_neg1", e.y_1_neg1, rsp_payload.y_1_neg1);
               check_field("y_2_0", e.y_2_0, rsp_payload.y_2_0);
               check_field("y_2_pos1", e.y_2_pos1, rsp_payload.y_2_pos1);
               check_field("y_2_neg1", e.y_2_neg1, rsp_payload.y_2_neg1);
               check_field("y_2_pos2", e.y_2_pos2, rsp_payload.y_2_pos2);
               check_field("y_2_neg2", e.y_2_neg2, rsp_payload.y_2_neg2);
            end
         end
         // One long hold-off early on so the pipeline and skid fill up.
         if (!hold_done && words_sent >= 100) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall);
         end
         // Watchdog on cycles without any handshake.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_RING_COUNT) grid_rings = val[8:0];
      else if (idx == CSR_POINTS_PER_RING) grid_points = val;
      csr_valid <= 1'b0;
   endtask

   task automatic drain_all();
      do @(posedge clock);
      while (grid_words.size() != 0 || req_valid || harmonic_exp.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic req_type grid_word(int ring, int point);
      req_type w;
      w.ring_index = ring[7:0];
      w.point_index = point[9:0];
      return w;
   endfunction

   // Queues one grid word for the driver.
   task automatic queue_word(req_type w);
      grid_words.insert(grid_words.size(), w);
   endtask

   // Stimulus: register settings per phase, directed corners, then random grid words.
   initial begin
      int ring_set[NUM_PHASES];
      int point_set[NUM_PHASES];
      int send_set[4];
      int recv_set[4];
      int nr, np;
      ring_set = '{16, 3, 256, 0, 511, 4, 0, 100};
      point_set = '{64, 1, 1024, 0, 2047, 2, 0, 1000};
      send_set = '{0, 64, 0, 31};
      recv_set = '{0, 0, 64, 31};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph == 6) begin
            ring_set[ph] = $urandom_range(256, 3);
            point_set[ph] = $urandom_range(1024, 1);
         end
         csr_write(CSR_RING_COUNT, CSR_DATA_W'(ring_set[ph]));
         csr_write(CSR_POINTS_PER_RING, CSR_DATA_W'(point_set[ph]));
         csr_write(CSR_SPARE, CSR_DATA_W'($urandom));
         send_idle = send_set[ph % 4];
         recv_stall = recv_set[ph % 4];
         nr = (grid_rings > 256) ? 256 : grid_rings;
         np = (grid_points > 1024) ? 1024 : grid_points;
         if (ph == 0) begin
            // Poles, last rings, first and last points, and the field extremes.
            queue_word(grid_word(0, 0));
            queue_word(grid_word(1, 0));
            queue_word(grid_word(1, np - 1));
            queue_word(grid_word(1, np));
            queue_word(grid_word(nr - 2, 0));
            queue_word(grid_word(nr - 1, 0));
            queue_word(grid_word(nr / 2, np / 4));
            queue_word(grid_word(nr / 2, np / 2));
            queue_word(grid_word(nr / 2, 3 * np / 4));
            queue_word(grid_word(255, 1023));
            queue_word(grid_word(255, 0));
            queue_word(grid_word(7, 1023));
            queue_word(grid_word(nr / 4, 1));
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (nr >= 3 && np >= 1 && $urandom_range(99) < 75)
               queue_word(grid_word($urandom_range(nr - 2, 1),
                                    $urandom_range(np - 1, 0)));
            else
               queue_word(grid_word($urandom_range(255, 0),
                                    $urandom_range(1023, 0)));
         end
         drain_all();
      end
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
